// ===== sv/ssm_pkg.sv =====
`timescale 1ns / 1ps

package ssm_pkg;

	// Field widths
	localparam int unsigned TEMP_W  = 13;
	localparam int unsigned MA_W    = 15;
	localparam int unsigned MV_W    = 16;
	localparam int unsigned TS_W    = 32;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DELAY_MS_W = 20;
	localparam int unsigned LIMIT_MS_W = 24;
	localparam int unsigned TICK_W     = 7;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FAULT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

	// External mode codes
	localparam logic [CODE_W-1:0] CODE_SLEEP = 3'd0;
	localparam logic [CODE_W-1:0] CODE_RUN   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_PRE   = 3'd2;
	localparam logic [CODE_W-1:0] CODE_STBY  = 3'd3;
	localparam logic [CODE_W-1:0] CODE_EMER  = 3'd4;
	localparam logic [CODE_W-1:0] CODE_HALT  = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STANDBY_DELAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAT_LIMIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STBY_TEMP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_TEMP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BUS_MV    = 3'd5;

	// Time scaling and thresholds
	localparam logic [DELAY_MS_W-1:0] MS_PER_S   = 20'd1000;
	localparam logic [LIMIT_MS_W-1:0] MS_PER_MIN = 24'd60000;
	localparam logic [TEMP_W-1:0] TIP_DELTA     = 13'd50;
	localparam logic [TEMP_W-1:0] TIP_COLD_TEMP = 13'd350;
	localparam logic [MA_W-1:0]   TIP_IDLE_MA   = 15'd50;
	localparam logic [TICK_W-1:0] STARTUP_TICKS = 7'd100;

	// Reset values of the configuration registers
	localparam logic [DELAY_MS_W-1:0] RST_STANDBY_DELAY_MS = 20'd10000;
	localparam logic [LIMIT_MS_W-1:0] RST_HEAT_LIMIT_MS    = 24'd0;
	localparam logic [TEMP_W-1:0]     RST_STBY_TEMP        = 13'd1500;
	localparam logic [LIMIT_MS_W-1:0] RST_SLEEP_MS         = 24'd600000;
	localparam logic [TEMP_W-1:0]     RST_SHUTDOWN_TEMP    = 13'd4900;
	localparam logic [MV_W-1:0]       RST_MIN_BUS_MV       = 16'd8000;

	typedef enum logic [5:0] {
		M_SLEEP = 6'b000001,
		M_RUN   = 6'b000010,
		M_PRE   = 6'b000100,
		M_STBY  = 6'b001000,
		M_EMER  = 6'b010000,
		M_HALT  = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [DELAY_MS_W-1:0] standby_delay_ms;
		logic [LIMIT_MS_W-1:0] heat_limit_ms;
		logic [TEMP_W-1:0]     stby_temp;
		logic [LIMIT_MS_W-1:0] sleep_ms;
		logic [TEMP_W-1:0]     shutdown_temp;
		logic [MV_W-1:0]       min_bus_mv;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              docked;
		logic [TEMP_W-1:0] temp_now;
		logic [TEMP_W-1:0] temp_prev;
		logic [MA_W-1:0]   heater_ma;
		logic [MV_W-1:0]   bus_mv;
		logic [TEMP_W-1:0] target_temp;
		logic [TS_W-1:0]   now_ms;
		logic [CODE_W-1:0] req_state;
	} item_t;

	typedef struct packed {
		mode_t             mode;
		mode_t             prior;
		logic [TEMP_W-1:0] setpoint;
		logic [TS_W-1:0]   run_start;
		logic [TS_W-1:0]   pre_start;
		logic [TS_W-1:0]   stby_start;
		logic              was_docked;
		logic              tip_present;
		logic [TICK_W-1:0] startup_cnt;
	} ctx_t;

	// Map an internal mode to its external code
	function automatic logic [CODE_W-1:0] mode_code(mode_t m);
		logic [CODE_W-1:0] c;
		unique case (m)
			M_RUN:   c = CODE_RUN;
			M_PRE:   c = CODE_PRE;
			M_STBY:  c = CODE_STBY;
			M_EMER:  c = CODE_EMER;
			M_HALT:  c = CODE_HALT;
			default: c = CODE_SLEEP;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/ssm_if.sv =====
`timescale 1ns / 1ps

interface ssm_req_if;
	import ssm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic              docked;
	logic [TEMP_W-1:0] temp_now;
	logic [TEMP_W-1:0] temp_prev;
	logic [MA_W-1:0]   heater_ma;
	logic [MV_W-1:0]   bus_mv;
	logic [TEMP_W-1:0] target_temp;
	logic [TS_W-1:0]   now_ms;
	logic [CODE_W-1:0] req_state;

	modport source (
		output valid, cmd, docked, temp_now, temp_prev, heater_ma, bus_mv,
			target_temp, now_ms, req_state,
		input ready
	);
	modport sink (
		input valid, cmd, docked, temp_now, temp_prev, heater_ma, bus_mv,
			target_temp, now_ms, req_state,
		output ready
	);
endinterface

interface ssm_rsp_if;
	import ssm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] mode;
	logic [CODE_W-1:0] prior_mode;
	logic [TEMP_W-1:0] setpoint;
	logic              heat_cut_pulse;
	logic              beep_double;

	modport source (
		output valid, mode, prior_mode, setpoint, heat_cut_pulse, beep_double,
		input ready
	);
	modport sink (
		input valid, mode, prior_mode, setpoint, heat_cut_pulse, beep_double,
		output ready
	);
endinterface

// ===== sv/ssm_cfg.sv =====
`timescale 1ns / 1ps

module ssm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]  index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0] wdata,
	output ssm_pkg::cfg_t                  cfg
);
	import ssm_pkg::*;

	cfg_t cfg_q;

	// Store registers, with timeouts scaled to milliseconds on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.standby_delay_ms <= RST_STANDBY_DELAY_MS;
			cfg_q.heat_limit_ms    <= RST_HEAT_LIMIT_MS;
			cfg_q.stby_temp        <= RST_STBY_TEMP;
			cfg_q.sleep_ms         <= RST_SLEEP_MS;
			cfg_q.shutdown_temp    <= RST_SHUTDOWN_TEMP;
			cfg_q.min_bus_mv       <= RST_MIN_BUS_MV;
		end else if (we) begin
			unique case (index)
				REG_STANDBY_DELAY: cfg_q.standby_delay_ms <=
					DELAY_MS_W'(wdata[9:0]) * MS_PER_S;
				REG_HEAT_LIMIT:    cfg_q.heat_limit_ms <=
					LIMIT_MS_W'(wdata[7:0]) * MS_PER_MIN;
				REG_STBY_TEMP:     cfg_q.stby_temp <= wdata[TEMP_W-1:0];
				REG_SLEEP_TIMEOUT: cfg_q.sleep_ms <=
					LIMIT_MS_W'(wdata[7:0]) * MS_PER_MIN;
				REG_SHUTDOWN_TEMP: cfg_q.shutdown_temp <= wdata[TEMP_W-1:0];
				REG_MIN_BUS_MV:    cfg_q.min_bus_mv <= wdata[MV_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/ssm_step.sv =====
`timescale 1ns / 1ps

module ssm_step (
	input  ssm_pkg::ctx_t  ctx,
	input  ssm_pkg::item_t item,
	input  ssm_pkg::cfg_t  cfg,
	output ssm_pkg::ctx_t  ctx_nxt,
	output logic           heat_cut,
	output logic           beep
);
	import ssm_pkg::*;

	typedef struct packed {
		ctx_t ctx;
		logic off;
		logic beep;
	} step_t;

	// Change mode and run the entry actions of the new mode
	function automatic step_t enter(step_t s, mode_t nxt, logic [TS_W-1:0] now,
			logic [TEMP_W-1:0] target);
		step_t r;
		r = s;
		if (nxt != s.ctx.mode) begin
			r.ctx.prior = s.ctx.mode;
			r.ctx.mode  = nxt;
			unique case (nxt)
				M_RUN: begin
					r.ctx.setpoint  = target;
					r.ctx.run_start = now;
				end
				M_PRE:  r.ctx.pre_start  = now;
				M_STBY: r.ctx.stby_start = now;
				M_EMER: begin
					r.ctx.setpoint = '0;
					r.off  = 1'b1;
					r.beep = 1'b1;
				end
				default: begin
					r.ctx.setpoint = '0;
					r.off = 1'b1;
				end
			endcase
		end
		return r;
	endfunction

	// Decode a requested state code
	function automatic mode_t code_mode(logic [CODE_W-1:0] c);
		mode_t m;
		unique case (c)
			CODE_RUN:  m = M_RUN;
			CODE_PRE:  m = M_PRE;
			CODE_STBY: m = M_STBY;
			CODE_EMER: m = M_EMER;
			CODE_HALT: m = M_HALT;
			default:   m = M_SLEEP;
		endcase
		return m;
	endfunction

	logic [TEMP_W-1:0] delta;
	logic [TS_W-1:0]   run_el, pre_el, stby_el;
	logic              heat_due, pre_due, sleep_due;
	logic [TEMP_W-1:0] stby_sp;
	step_t             s;

	// Elapsed times on the wrapping timestamp
	assign delta   = (item.temp_now > item.temp_prev) ? item.temp_now - item.temp_prev
		: item.temp_prev - item.temp_now;
	assign run_el  = item.now_ms - ctx.run_start;
	assign pre_el  = item.now_ms - ctx.pre_start;
	assign stby_el = item.now_ms - ctx.stby_start;
	assign heat_due  = (cfg.heat_limit_ms != '0) && (run_el >= TS_W'(cfg.heat_limit_ms));
	assign pre_due   = pre_el >= TS_W'(cfg.standby_delay_ms);
	assign sleep_due = (cfg.sleep_ms != '0) && (stby_el >= TS_W'(cfg.sleep_ms));
	assign stby_sp   = (cfg.stby_temp > item.target_temp) ? item.target_temp
		: cfg.stby_temp;

	// Apply one request to the mode context
	always_comb begin
		s.ctx  = ctx;
		s.off  = 1'b0;
		s.beep = 1'b0;
		unique case (item.cmd)
			CMD_UPDATE: begin
				if (delta > TIP_DELTA) begin
					s.ctx.tip_present = 1'b1;
				end else if (item.heater_ma < TIP_IDLE_MA && item.temp_now < TIP_COLD_TEMP) begin
					s.ctx.tip_present = 1'b0;
				end
				unique case (ctx.mode)
					M_RUN: begin
						s.ctx.setpoint = item.target_temp;
						if (item.docked && !ctx.was_docked) begin
							s = enter(s, (cfg.standby_delay_ms != '0) ? M_PRE : M_STBY,
								item.now_ms, item.target_temp);
						end
						if (heat_due) begin
							s = enter(s, M_EMER, item.now_ms, item.target_temp);
						end
					end
					M_PRE: begin
						if (!item.docked && ctx.was_docked) begin
							s = enter(s, M_RUN, item.now_ms, item.target_temp);
						end else if (pre_due) begin
							s = enter(s, M_STBY, item.now_ms, item.target_temp);
						end
					end
					M_STBY: begin
						if (!item.docked) begin
							s = enter(s, M_RUN, item.now_ms, item.target_temp);
						end else begin
							s.ctx.setpoint = stby_sp;
							if (sleep_due) begin
								s = enter(s, M_SLEEP, item.now_ms, item.target_temp);
							end
						end
					end
					M_SLEEP: begin
						s.ctx.setpoint = '0;
						s.off = 1'b1;
						if (!item.docked && s.ctx.tip_present) begin
							s = enter(s, M_RUN, item.now_ms, item.target_temp);
						end
					end
					default: begin
						s.ctx.setpoint = '0;
						s.off = 1'b1;
					end
				endcase
				s.ctx.was_docked = item.docked;
			end
			CMD_FAULT: begin
				if (ctx.startup_cnt < STARTUP_TICKS) begin
					s.ctx.startup_cnt = ctx.startup_cnt + 1'b1;
				end else if (item.temp_now > cfg.shutdown_temp) begin
					s = enter(s, M_EMER, item.now_ms, item.target_temp);
				end else if (item.bus_mv < cfg.min_bus_mv && ctx.mode == M_RUN) begin
					s = enter(s, M_EMER, item.now_ms, item.target_temp);
				end
			end
			CMD_REQUEST: begin
				if (item.req_state <= CODE_HALT) begin
					s = enter(s, code_mode(item.req_state), item.now_ms, item.target_temp);
				end
			end
			CMD_NOP: ;
			default: ;
		endcase
	end

	assign ctx_nxt  = s.ctx;
	assign heat_cut = s.off;
	assign beep     = s.beep;

endmodule

// ===== sv/solder_station_mode_fsm_core.sv =====
`timescale 1ns / 1ps

// Soldering-station mode machine.
// req_ch carries one command per request: update tick, fault-check tick or
// forced state change. rsp_ch returns exactly one result per request: mode,
// prior mode, setpoint and the heater-off and double-beep pulses.
// cfg_we/cfg_index/cfg_wdata write the six settings; write only while no
// request is in flight. Timeouts are scaled to milliseconds as they are written.
// A request accepted into the input register is processed by one pass of
// compare logic, and its result is loaded into the output register.
// Throughput: one request per cycle while rsp_ch.ready is high; the mode
// context loads at the same edge as the result, so the next request sees it.
// The output register holds its result while rsp_ch.ready is low; the input
// register then still takes one more request, and req_ch.ready drops once
// both are full.
// Reset (arst_n low) clears both registers, puts the machine in sleep with a
// zero setpoint and zeroed timestamps, and restores the default settings.
module solder_station_mode_fsm_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ssm_req_if.sink                        req_ch,
	ssm_rsp_if.source                      rsp_ch
);
	import ssm_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	ctx_t  ctx_q;
	ctx_t  ctx_nxt;
	logic  heat_cut, beep;
	logic  advance;

	logic              rsp_valid_q;
	logic [CODE_W-1:0] mode_q, prior_q;
	logic [TEMP_W-1:0] setpoint_q;
	logic              off_q, beep_q;

	ssm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	ssm_step u_step (
		.ctx      (ctx_q),
		.item     (item_s1),
		.cfg      (cfg),
		.ctx_nxt  (ctx_nxt),
		.heat_cut (heat_cut),
		.beep     (beep)
	);

	// Advance when the output register is free or being drained
	assign advance      = valid_s1 && (!rsp_valid_q || rsp_ch.ready);
	assign req_ch.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			item_s1.cmd         <= req_ch.cmd;
			item_s1.docked      <= req_ch.docked;
			item_s1.temp_now    <= req_ch.temp_now;
			item_s1.temp_prev   <= req_ch.temp_prev;
			item_s1.heater_ma   <= req_ch.heater_ma;
			item_s1.bus_mv      <= req_ch.bus_mv;
			item_s1.target_temp <= req_ch.target_temp;
			item_s1.now_ms      <= req_ch.now_ms;
			item_s1.req_state   <= req_ch.req_state;
		end
	end

	// Mode context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.mode        <= M_SLEEP;
			ctx_q.prior       <= M_SLEEP;
			ctx_q.setpoint    <= '0;
			ctx_q.run_start   <= '0;
			ctx_q.pre_start   <= '0;
			ctx_q.stby_start  <= '0;
			ctx_q.was_docked  <= 1'b0;
			ctx_q.tip_present <= 1'b0;
			ctx_q.startup_cnt <= '0;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_q     <= mode_code(ctx_nxt.mode);
			prior_q    <= mode_code(ctx_nxt.prior);
			setpoint_q <= ctx_nxt.setpoint;
			off_q      <= heat_cut;
			beep_q     <= beep;
		end
	end

	assign rsp_ch.valid          = rsp_valid_q;
	assign rsp_ch.mode           = mode_q;
	assign rsp_ch.prior_mode     = prior_q;
	assign rsp_ch.setpoint       = setpoint_q;
	assign rsp_ch.heat_cut_pulse = off_q;
	assign rsp_ch.beep_double    = beep_q;

endmodule
